/* design/adeq_pkg.sv */
// package for the array double-ended queue
// holds command and status codes and the controller/datapath interface types
// no dependencies
package adeq_pkg;

   // default number of entries in the queue array
   localparam int unsigned DEPTH_DEFAULT = 16;

   localparam int unsigned DATA_W = 32;

   // request commands
   typedef enum logic [1:0] {
      CMD_PUSH_REAR  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_OK            = 2'd0,
      STAT_REAR_OVERFLOW = 2'd1,
      STAT_FRONT_NO_ROOM = 2'd2,
      STAT_UNDERFLOW     = 2'd3
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;      // accept a transaction this cycle
      logic       wr_en;     // store the request value
      logic       rd_en;     // read out an entry
      logic       at_front;  // operate on the front end, else the rear
      status_type status;    // status code of the transaction
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;       // front and rear marks meet
      logic front_zero;  // no freed slot before the front
      logic rear_full;   // rear mark is past the last slot
   } dp_flags_type;

endpackage

/* design/adeq_ctrl.sv */
// controller for the array double-ended queue
// handles both handshakes and decodes each command against the datapath flags
// depends on adeq_pkg
module adeq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  adeq_pkg::dp_flags_type flags,
   output adeq_pkg::dp_cmd_type   dp_cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      load;

   // a new transaction may enter when the output register is free or draining
   assign rsp_valid = (state_ff == S_HOLD);
   assign req_ready = !rsp_valid || rsp_ready;
   assign load      = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (load) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_ready && !load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // command decode against queue bounds
   always_comb begin
      dp_cmd          = '0;
      dp_cmd.load     = load;
      dp_cmd.status   = adeq_pkg::STAT_OK;
      case (adeq_pkg::cmd_type'(req_cmd))
         adeq_pkg::CMD_PUSH_REAR: begin
            dp_cmd.at_front = 1'b0;
            if (flags.rear_full) dp_cmd.status = adeq_pkg::STAT_REAR_OVERFLOW;
            else                 dp_cmd.wr_en  = load;
         end
         adeq_pkg::CMD_PUSH_FRONT: begin
            dp_cmd.at_front = 1'b1;
            if (flags.front_zero) dp_cmd.status = adeq_pkg::STAT_FRONT_NO_ROOM;
            else                  dp_cmd.wr_en  = load;
         end
         adeq_pkg::CMD_POP_FRONT: begin
            dp_cmd.at_front = 1'b1;
            if (flags.empty) dp_cmd.status = adeq_pkg::STAT_UNDERFLOW;
            else             dp_cmd.rd_en  = load;
         end
         adeq_pkg::CMD_POP_REAR: begin
            dp_cmd.at_front = 1'b0;
            if (flags.empty) dp_cmd.status = adeq_pkg::STAT_UNDERFLOW;
            else             dp_cmd.rd_en  = load;
         end
         default: dp_cmd.status = adeq_pkg::STAT_OK;
      endcase
   end

endmodule

/* design/adeq_dpath.sv */
// datapath for the array double-ended queue
// holds the entry memory, the front and rear marks and the response register
// depends on adeq_pkg
module adeq_dpath #(
   parameter int unsigned DEPTH = adeq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [adeq_pkg::DATA_W-1:0] req_value,
   input  adeq_pkg::dp_cmd_type        dp_cmd,
   output adeq_pkg::dp_flags_type      flags,
   output logic signed [adeq_pkg::DATA_W-1:0] rsp_popped,
   output logic [1:0]                  rsp_status
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned MW = $clog2(DEPTH + 1);

   logic [adeq_pkg::DATA_W-1:0] mem [DEPTH];

   logic [MW-1:0] front_ff, front_in;
   logic [MW-1:0] rear_ff, rear_in;
   logic [MW-1:0] front_dec, rear_dec;
   logic [AW-1:0] wr_addr, rd_addr;

   logic signed [adeq_pkg::DATA_W-1:0] popped_ff;
   adeq_pkg::status_type               status_ff;

   // bound flags
   assign flags.empty      = (front_ff == rear_ff);
   assign flags.front_zero = (front_ff == '0);
   assign flags.rear_full  = (rear_ff == MW'(DEPTH));

   assign front_dec = front_ff - MW'(1);
   assign rear_dec  = rear_ff - MW'(1);

   // slot addresses: pushes land just outside an end, pops take the end entry
   assign wr_addr = dp_cmd.at_front ? front_dec[AW-1:0] : rear_ff[AW-1:0];
   assign rd_addr = dp_cmd.at_front ? front_ff[AW-1:0]  : rear_dec[AW-1:0];

   // mark updates
   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      if (dp_cmd.wr_en) begin
         if (dp_cmd.at_front) front_in = front_dec;
         else                 rear_in  = rear_ff + MW'(1);
      end else if (dp_cmd.rd_en) begin
         if (dp_cmd.at_front) front_in = front_ff + MW'(1);
         else                 rear_in  = rear_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   // entry memory write port
   always_ff @(posedge clock) begin
      if (dp_cmd.wr_en) mem[wr_addr] <= req_value;
   end

   // registered read into the response register
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         if (dp_cmd.rd_en) popped_ff <= mem[rd_addr];
         else              popped_ff <= '1;
         status_ff <= dp_cmd.status;
      end
   end

   assign rsp_popped = popped_ff;
   assign rsp_status = status_ff;

endmodule

/* design/array_double_ended_queue.sv */
// top level of the array double-ended queue
// joins the controller and the datapath; depends on adeq_pkg, adeq_ctrl, adeq_dpath
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   request | req_valid req_ready req_cmd req_value  | in
//   result  | rsp_valid rsp_ready rsp_popped rsp_status | out
//
// every transaction yields one result in the cycle after acceptance
// one transaction per cycle is sustained while results are taken; the response register is the only stage
// reset empties the queue; entry contents are not cleared
// a stalled result blocks new requests until it is taken
module array_double_ended_queue #(
   parameter int unsigned DEPTH = adeq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic signed [adeq_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [adeq_pkg::DATA_W-1:0]  rsp_popped,
   output logic [1:0]                          rsp_status
);

   adeq_pkg::dp_cmd_type   dp_cmd;
   adeq_pkg::dp_flags_type flags;

   // handshake and command decode
   adeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .dp_cmd    (dp_cmd)
   );

   // storage and response register
   adeq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .dp_cmd     (dp_cmd),
      .flags      (flags),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status)
   );

endmodule

/* design/adeq_checker.sv */
// port-level checker for the array double-ended queue
// bound to the top level; depends on adeq_pkg
module adeq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [adeq_pkg::DATA_W-1:0]  rsp_popped,
   input logic [1:0]                          rsp_status
);

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every accepted transaction is answered in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no result after accepted request");

   // failed transactions never carry a popped value
   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != adeq_pkg::STAT_OK)) |-> (rsp_popped == '1))
      else $error("failed transaction carries a value");

   // stalled result holds
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_popped) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind array_double_ended_queue adeq_checker u_adeq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_popped (rsp_popped),
   .rsp_status (rsp_status)
);

/* tb/sv/testbench.sv */
// self-checking testbench for the array double-ended queue
// drives commands with random idling on both channels and checks every result
// against a shadow queue; depends on adeq_pkg and array_double_ended_queue
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUEUE_DEPTH  = adeq_pkg::DEPTH_DEFAULT;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned MAX_IDLE     = 14;

   localparam logic signed [adeq_pkg::DATA_W-1:0] VALUE_MIN =
      {1'b1, {(adeq_pkg::DATA_W-1){1'b0}}};
   localparam logic signed [adeq_pkg::DATA_W-1:0] VALUE_MAX =
      {1'b0, {(adeq_pkg::DATA_W-1){1'b1}}};

   typedef struct packed {
      logic signed [adeq_pkg::DATA_W-1:0] popped;
      adeq_pkg::status_type               status;
   } outcome_type;

   typedef enum int unsigned {
      MODE_FILL_REAR,
      MODE_DRAIN_FRONT,
      MODE_DRAIN_REAR,
      MODE_FRONT_REFILL,
      MODE_UNIFORM
   } traffic_mode_type;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [1:0]                         req_cmd   = adeq_pkg::CMD_PUSH_REAR;
   logic signed [adeq_pkg::DATA_W-1:0] req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b1;
   logic signed [adeq_pkg::DATA_W-1:0] rsp_popped;
   logic [1:0]                         rsp_status;

   // shadow copy of the queue
   logic signed [adeq_pkg::DATA_W-1:0] slot_data [QUEUE_DEPTH];
   int unsigned                        head_mark = 0;
   int unsigned                        tail_mark = 0;

   outcome_type expected_outcomes [$];
   int unsigned fault_count   = 0;
   int unsigned idle_cycles   = 0;
   bit          quiet_phase   = 1'b0;
   int unsigned send_gap_odds = 6;

   always #5 clock = ~clock;

   array_double_ended_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_popped (rsp_popped),
      .rsp_status (rsp_status)
   );

   // apply one command to the shadow queue and return its result
   function automatic outcome_type apply_command(
      input adeq_pkg::cmd_type op,
      input logic signed [adeq_pkg::DATA_W-1:0] val);
      outcome_type result;
      result.popped = '1;
      result.status = adeq_pkg::STAT_OK;
      case (op)
         adeq_pkg::CMD_PUSH_REAR: begin
            if (tail_mark >= QUEUE_DEPTH) begin
               result.status = adeq_pkg::STAT_REAR_OVERFLOW;
            end else begin
               slot_data[tail_mark] = val;
               tail_mark++;
            end
         end
         adeq_pkg::CMD_PUSH_FRONT: begin
            if (head_mark == 0) begin
               result.status = adeq_pkg::STAT_FRONT_NO_ROOM;
            end else begin
               head_mark--;
               slot_data[head_mark] = val;
            end
         end
         adeq_pkg::CMD_POP_FRONT: begin
            if (head_mark == tail_mark) begin
               result.status = adeq_pkg::STAT_UNDERFLOW;
            end else begin
               result.popped = slot_data[head_mark];
               head_mark++;
            end
         end
         default: begin
            if (head_mark == tail_mark) begin
               result.status = adeq_pkg::STAT_UNDERFLOW;
            end else begin
               tail_mark--;
               result.popped = slot_data[tail_mark];
            end
         end
      endcase
      return result;
   endfunction

   // one request transaction; valid stays high into the next call unless a gap is taken
   task automatic send_item(input adeq_pkg::cmd_type op,
                            input logic signed [adeq_pkg::DATA_W-1:0] val);
      req_valid <= 1'b1;
      req_cmd   <= op;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      expected_outcomes.push_back(apply_command(op, val));
      if (!quiet_phase && send_gap_odds != 0 && $urandom_range(send_gap_odds - 1, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(MAX_IDLE, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [adeq_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(7, 0))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly the command that the mode favors, the rest noise
   function automatic adeq_pkg::cmd_type pick_command(input traffic_mode_type mode);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      case (mode)
         MODE_FILL_REAR:   if (roll < 80) return adeq_pkg::CMD_PUSH_REAR;
         MODE_DRAIN_FRONT: if (roll < 80) return adeq_pkg::CMD_POP_FRONT;
         MODE_DRAIN_REAR:  if (roll < 80) return adeq_pkg::CMD_POP_REAR;
         MODE_FRONT_REFILL: begin
            if (roll < 40) return adeq_pkg::CMD_POP_FRONT;
            if (roll < 80) return adeq_pkg::CMD_PUSH_FRONT;
         end
         default: ;
      endcase
      return adeq_pkg::cmd_type'($urandom_range(3, 0));
   endfunction

   // pops and front push on an empty queue
   task automatic test_empty_queue();
      send_item(adeq_pkg::CMD_POP_FRONT, pick_value());
      send_item(adeq_pkg::CMD_POP_REAR, pick_value());
      send_item(adeq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
   endtask

   // extreme values, a front push into the freed slot, front with no room,
   // and a popped value of all ones with ok status
   task automatic test_front_room();
      send_item(adeq_pkg::CMD_PUSH_REAR, VALUE_MIN);
      send_item(adeq_pkg::CMD_PUSH_REAR, VALUE_MAX);
      send_item(adeq_pkg::CMD_PUSH_REAR, '0);
      send_item(adeq_pkg::CMD_PUSH_REAR, '1);
      send_item(adeq_pkg::CMD_POP_FRONT, '0);
      send_item(adeq_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
      send_item(adeq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
      send_item(adeq_pkg::CMD_POP_REAR, '0);
      send_item(adeq_pkg::CMD_POP_FRONT, '1);
   endtask

   // fill the rear up to the last slot, then push once more
   task automatic test_rear_overflow();
      while (tail_mark < QUEUE_DEPTH) send_item(adeq_pkg::CMD_PUSH_REAR, $urandom);
      send_item(adeq_pkg::CMD_PUSH_REAR, pick_value());
   endtask

   // bursts of biased traffic with random idling
   task automatic test_random_mix(input int unsigned item_count);
      int unsigned      sent;
      int unsigned      burst_len;
      traffic_mode_type mode;
      sent = 0;
      while (sent < item_count) begin
         mode          = traffic_mode_type'($urandom_range(4, 0));
         burst_len     = $urandom_range(40, 8);
         send_gap_odds = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 3);
         for (int unsigned i = 0; i < burst_len && sent < item_count; i++) begin
            send_item(pick_command(mode), pick_value());
            sent++;
         end
      end
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_steady_stream(input int unsigned item_count);
      quiet_phase = 1'b1;
      test_random_mix(item_count);
   endtask

   // result channel stalls in random bursts
   always begin
      if (!quiet_phase && $urandom_range(5, 0) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(MAX_IDLE, 1)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(24, 1)) @(posedge clock);
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            if (fault_count < MAX_REPORTS)
               $display("unexpected result: popped %0d status %0d", rsp_popped, rsp_status);
            fault_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_popped !== want.popped || rsp_status !== want.status) begin
               if (fault_count < MAX_REPORTS)
                  $display("mismatch: popped exp %0d got %0d, status exp %0d got %0d",
                           want.popped, rsp_popped, want.status, rsp_status);
               fault_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // reset, test sequence and final verdict
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_front_room();
      test_rear_overflow();
      test_random_mix(800);
      test_steady_stream(400);
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* array_double_ended_queue.f */
design/adeq_pkg.sv
design/adeq_ctrl.sv
design/adeq_dpath.sv
design/array_double_ended_queue.sv
design/adeq_checker.sv
tb/sv/testbench.sv
